@@ src/dura_pkg.sv @@
`default_nettype none

package dura_pkg;

    // Input operation codes.
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ECHO_ONE = 2'd1;
    localparam logic [1:0] OP_ECHO_TWO = 2'd2;

    // Sensor numbers as they appear on the trigger output and in the arm state.
    localparam logic [1:0] SENSOR_NONE = 2'd0;
    localparam logic [1:0] SENSOR_ONE  = 2'd1;
    localparam logic [1:0] SENSOR_TWO  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_WARN_DISTANCE  = 2'd0;
    localparam logic [1:0] REG_MAX_DISTANCE   = 2'd1;
    localparam logic [1:0] REG_TICKS_PER_SLOT = 2'd2;
    localparam logic [1:0] REG_LONGEST_BLINK  = 2'd3;

    // Configuration reset values.
    localparam logic [8:0] WARN_DISTANCE_RESET  = 9'd40;
    localparam logic [8:0] MAX_DISTANCE_RESET   = 9'd380;
    localparam logic [3:0] TICKS_PER_SLOT_RESET = 4'd5;
    localparam logic [3:0] LONGEST_BLINK_RESET  = 4'd4;

    // Nearest distance after reset, in cm.
    localparam logic [8:0] NEAR_RESET = 9'd300;

    // floor(x / 58) for x below 2^15 as (x * 36158) >> 21.
    localparam logic [15:0] ECHO_RECIP = 16'd36158;
    localparam int          ECHO_SHIFT = 21;

    // floor(x / 10) for x below 2^10 as (x * 205) >> 11.
    localparam logic [7:0] TENTH_RECIP = 8'd205;
    localparam int         TENTH_SHIFT = 11;

    typedef struct packed {
        logic [8:0] warn_distance;
        logic [8:0] max_distance;
        logic [3:0] ticks_per_slot;
        logic [3:0] longest_blink;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  slot_ticks;
        logic [1:0]  turn;
        logic [1:0]  armed_sensor;
        logic        rise_seen;
        logic [15:0] rise_stamp;
        logic [8:0]  dist_one;
        logic [8:0]  dist_two;
        logic [8:0]  dist_near;
        logic        warn_flag;
        logic [3:0]  blink_count;
        logic        buzzer_level;
        logic        led_level;
    } state_t;

    localparam state_t STATE_RESET = '{
        slot_ticks:   4'd0,
        turn:         SENSOR_NONE,
        armed_sensor: SENSOR_NONE,
        rise_seen:    1'b0,
        rise_stamp:   16'd0,
        dist_one:     9'd0,
        dist_two:     9'd0,
        dist_near:    NEAR_RESET,
        warn_flag:    1'b0,
        blink_count:  4'd0,
        buzzer_level: 1'b0,
        led_level:    1'b1
    };

    // Result beat, packed from the lowest bit: trigger_sensor first.
    typedef struct packed {
        logic       warning;
        logic [8:0] nearest_range;
        logic [8:0] range_two;
        logic [8:0] range_one;
        logic       led_off;
        logic       buzzer_on;
        logic [1:0] trigger_sensor;
    } result_t;

endpackage

`default_nettype wire

@@ src/dura_cfg.sv @@
`default_nettype none

module dura_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          write_en,
    input  wire logic [1:0]    write_index,
    input  wire logic [8:0]    write_data,
    output dura_pkg::cfg_t     cfg
);
    import dura_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register file decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (write_index)
                REG_WARN_DISTANCE:  cfg_next.warn_distance  = write_data;
                REG_MAX_DISTANCE:   cfg_next.max_distance   = write_data;
                REG_TICKS_PER_SLOT: cfg_next.ticks_per_slot = write_data[3:0];
                REG_LONGEST_BLINK:  cfg_next.longest_blink  = write_data[3:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warn_distance  <= WARN_DISTANCE_RESET;
            cfg_reg.max_distance   <= MAX_DISTANCE_RESET;
            cfg_reg.ticks_per_slot <= TICKS_PER_SLOT_RESET;
            cfg_reg.longest_blink  <= LONGEST_BLINK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/dura_step.sv @@
`default_nettype none

module dura_step (
    input  wire dura_pkg::cfg_t   cfg,
    input  wire dura_pkg::state_t cur,
    input  wire logic [1:0]       operation,
    input  wire logic [15:0]      edge_time,
    output dura_pkg::state_t      nxt,
    output dura_pkg::result_t     result
);
    import dura_pkg::*;

    logic [3:0]  slot_limit;
    logic [4:0]  ticks_inc;
    logic        slot_fire;
    logic [1:0]  turn_next;
    logic [8:0]  near_sel;
    logic [16:0] tenth_prod;
    logic [5:0]  near_tenth;
    logic [5:0]  period_raw;
    logic [3:0]  blink_top;
    logic [3:0]  period;
    logic [4:0]  blink_inc;
    logic        warn_next;
    logic [15:0] echo_width;
    logic [30:0] echo_prod;
    logic [9:0]  echo_dist;
    logic        echo_match;

    // Slot timing: a zero slot length acts as one tick.
    assign slot_limit = (cfg.ticks_per_slot == 4'd0) ? 4'd1 : cfg.ticks_per_slot;
    assign ticks_inc  = {1'b0, cur.slot_ticks} + 5'd1;
    assign slot_fire  = (operation == OP_TICK) && (ticks_inc >= {1'b0, slot_limit});

    // The sensors take turns; the first slot after reset serves sensor one.
    assign turn_next = (cur.turn == SENSOR_ONE) ? SENSOR_TWO : SENSOR_ONE;

    // Nearer reading when both readings are nonzero, otherwise the previous nearest distance.
    always_comb
    begin
        if ((cur.dist_one <= cur.dist_two) && (cur.dist_one != 9'd0))
            near_sel = cur.dist_one;
        else if ((cur.dist_two < cur.dist_one) && (cur.dist_two != 9'd0))
            near_sel = cur.dist_two;
        else
            near_sel = cur.dist_near;
    end

    assign warn_next = (near_sel <= cfg.warn_distance);

    // Blink period is nearest/10 + 1, clamped to the longest blink setting.
    assign tenth_prod = 17'(near_sel) * 17'(TENTH_RECIP);
    assign near_tenth = tenth_prod[TENTH_SHIFT +: 6];
    assign period_raw = near_tenth + 6'd1;
    assign blink_top  = (cfg.longest_blink == 4'd0) ? 4'd1 : cfg.longest_blink;
    assign period     = (period_raw > {2'b00, blink_top}) ? blink_top : period_raw[3:0];
    assign blink_inc  = {1'b0, cur.blink_count} + 5'd1;

    // Echo pulse width in half microseconds, halved, divided by 58.
    assign echo_width = edge_time - cur.rise_stamp;
    assign echo_prod  = 31'(echo_width[15:1]) * 31'(ECHO_RECIP);
    assign echo_dist  = echo_prod[ECHO_SHIFT +: 10];
    assign echo_match = ((operation == OP_ECHO_ONE) || (operation == OP_ECHO_TWO))
                        && (cur.armed_sensor == operation);

    // Next state.
    always_comb
    begin
        nxt = cur;
        if (operation == OP_TICK)
        begin
            nxt.slot_ticks = slot_fire ? 4'd0 : ticks_inc[3:0];
            if (slot_fire)
            begin
                nxt.turn         = turn_next;
                nxt.armed_sensor = turn_next;
                nxt.rise_seen    = 1'b0;
                nxt.dist_near    = near_sel;
                nxt.warn_flag    = warn_next;
                if (warn_next)
                begin
                    if (blink_inc >= {1'b0, period})
                    begin
                        nxt.blink_count  = 4'd0;
                        nxt.buzzer_level = ~cur.buzzer_level;
                        nxt.led_level    = ~cur.led_level;
                    end
                    else
                    begin
                        nxt.blink_count = blink_inc[3:0];
                    end
                end
                else
                begin
                    nxt.buzzer_level = 1'b0;
                    nxt.led_level    = 1'b1;
                end
            end
        end
        else if (echo_match)
        begin
            if (!cur.rise_seen)
            begin
                nxt.rise_stamp = edge_time;
                nxt.rise_seen  = 1'b1;
            end
            else
            begin
                // Readings beyond the maximum keep the old distance.
                if (echo_dist <= {1'b0, cfg.max_distance})
                begin
                    if (operation == OP_ECHO_ONE)
                        nxt.dist_one = echo_dist[8:0];
                    else
                        nxt.dist_two = echo_dist[8:0];
                end
                nxt.rise_seen    = 1'b0;
                nxt.armed_sensor = SENSOR_NONE;
            end
        end
    end

    // Result beat shows the state after this item.
    always_comb
    begin
        result.trigger_sensor = slot_fire ? turn_next : SENSOR_NONE;
        result.buzzer_on      = nxt.buzzer_level;
        result.led_off        = nxt.led_level;
        result.range_one      = nxt.dist_one;
        result.range_two      = nxt.dist_two;
        result.nearest_range  = nxt.dist_near;
        result.warning        = nxt.warn_flag;
    end

endmodule

`default_nettype wire

@@ src/dual_ultrasonic_ranging_alarm_top.sv @@
// Dual ultrasonic ranging proximity alarm.
//
// Input beats on s_*: s_tuser carries the operation (tick, echo edge of
// sensor one, echo edge of sensor two), s_tdata the timer value of the edge.
// Each accepted input beat gives exactly one result beat on m_*, carrying the
// trigger pulse request, buzzer and LED levels, both ranges, the nearest range
// and the warning flag as they stand after that beat.
// The cfg_* channel writes the four setting registers; it is always ready and
// should only be used while no beat is in flight.
//
// The input register loads at the accepting edge and the whole update runs
// combinationally from it into the result register, which loads once it is
// free or being read. Throughput is one beat per cycle while the receiver
// takes results; the state update of one beat is ready for the next beat in
// the following cycle.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more beat before s_tready drops.
// Reset clears both pipeline registers, returns the settings to their defaults
// and puts the ranging state in its idle form with the LED dark.
`default_nettype none

module dual_ultrasonic_ranging_alarm_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] edge_time
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [31:0] m_tdata,   // [1:0] trigger_sensor, [2] buzzer_on,
                                        // [3] led_off, [12:4] range_one,
                                        // [21:13] range_two, [30:22] nearest_range,
                                        // [31] warning
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);
    import dura_pkg::*;

    cfg_t        cfg;
    state_t      state_reg;
    state_t      state_next;
    result_t     result_next;
    result_t     out_reg;
    logic        out_valid_reg;
    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [15:0] in_time_reg;
    logic        advance;
    logic        in_take;

    assign cfg_ready = 1'b1;

    dura_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (cfg_valid),
        .write_index (cfg_index),
        .write_data  (cfg_data),
        .cfg         (cfg)
    );

    dura_step u_step (
        .cfg       (cfg),
        .cur       (state_reg),
        .operation (in_op_reg),
        .edge_time (in_time_reg),
        .nxt       (state_next),
        .result    (result_next)
    );

    // The held beat moves on when the result register is free or being read.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg   <= s_tuser;
            in_time_reg <= s_tdata;
        end
    end

    // Ranging state commits when its beat moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // A pending rise stamp belongs to an armed sensor.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.rise_seen |-> (state_reg.armed_sensor != SENSOR_NONE))
    else $error("rise flag set with no sensor armed");

    // A fired trigger arms that same sensor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (result_next.trigger_sensor != SENSOR_NONE))
        |=> (state_reg.armed_sensor == out_reg.trigger_sensor))
    else $error("triggered sensor not armed");

    // Without a warning the buzzer is silent and the LED is dark.
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.warn_flag |-> (!state_reg.buzzer_level && state_reg.led_level))
    else $error("alarm outputs active without warning");

    // Input is refused only while both registers hold beats and output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
    else $error("input stalled with room in the pipeline");

    // A beat delivered with no new one behind it empties the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && m_tready && !advance) |=> !out_valid_reg)
    else $error("result beat repeated");

endmodule

`default_nettype wire

@@ verif/tb_dual_ultrasonic_ranging_alarm_top.sv @@
`default_nettype none

module tb_dual_ultrasonic_ranging_alarm_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dura_pkg::*;

    // Operation code that the block does not use.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Echo width in timer counts for one cm, there and back, and blink step in cm.
    localparam int unsigned SOUND_DIVISOR = 58;
    localparam int unsigned COUNTS_PER_CM = 2 * SOUND_DIVISOR;
    localparam int unsigned PERIOD_STEP   = 10;

    localparam int N_PHASES       = 6;
    localparam int RANDOM_PHASE   = 5;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int STALL_LONG     = 80;
    localparam int MAX_REPORTS    = 10;

    // Outputs right after reset, and after the first slot fires sensor one.
    localparam result_t IDLE_VIEW = '{
        warning:        1'b0,
        nearest_range:  NEAR_RESET,
        range_two:      9'd0,
        range_one:      9'd0,
        led_off:        1'b1,
        buzzer_on:      1'b0,
        trigger_sensor: SENSOR_NONE
    };
    localparam result_t FIRST_SLOT_VIEW = '{
        warning:        1'b0,
        nearest_range:  NEAR_RESET,
        range_two:      9'd0,
        range_one:      9'd0,
        led_off:        1'b1,
        buzzer_on:      1'b0,
        trigger_sensor: SENSOR_ONE
    };

    typedef struct {
        logic [1:0]  op;
        logic [15:0] stamp;
        bit          typed;
        result_t     want;
    } probe_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'd0;
    logic [1:0]  s_tuser   = OP_TICK;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_WARN_DISTANCE;
    logic [8:0]  cfg_data  = 9'd0;

    // Settings and ranging state as the block should hold them.
    cfg_t        settings = '{WARN_DISTANCE_RESET, MAX_DISTANCE_RESET,
                              TICKS_PER_SLOT_RESET, LONGEST_BLINK_RESET};
    logic [3:0]  slot_count    = 4'd0;
    logic [1:0]  turn_sel      = SENSOR_NONE;
    logic [1:0]  armed_unit    = SENSOR_NONE;
    logic        rise_pending  = 1'b0;
    logic [15:0] echo_start    = 16'd0;
    logic [8:0]  range_one_cm  = 9'd0;
    logic [8:0]  range_two_cm  = 9'd0;
    logic [8:0]  nearest_cm    = NEAR_RESET;
    logic        warn_on       = 1'b0;
    logic [3:0]  blink_count   = 4'd0;
    logic        buzz_level    = 1'b0;
    logic        led_dark      = 1'b1;

    result_t     pending_results [$];
    result_t     last_result;

    // Idle control that the stimulus sets for itself and for the result sink.
    bit          send_gaps = 1'b1;
    bit          recv_gaps = 1'b1;
    int          hold_req  = 0;

    int          useful_items     = 0;
    int          slots_fired      = 0;
    int          readings_kept    = 0;
    int          readings_dropped = 0;
    int          results_checked  = 0;
    int          warn_beats       = 0;
    int          mismatch_count   = 0;
    int          unexpected_count = 0;
    int          reports          = 0;

    // Directed beats: idle behavior, the first slot, a wrapped echo, an echo
    // beyond the range limit and a zero reading that must not become nearest.
    probe_t probes [25] = '{
        '{OP_TICK,     16'h0000, 1'b1, IDLE_VIEW},
        '{OP_ECHO_ONE, 16'hFFFF, 1'b1, IDLE_VIEW},
        '{OP_ECHO_TWO, 16'h0000, 1'b1, IDLE_VIEW},
        '{OP_SPARE,    16'hFFFF, 1'b1, IDLE_VIEW},
        '{OP_TICK,     16'hFFFF, 1'b1, IDLE_VIEW},
        '{OP_TICK,     16'hAAAA, 1'b1, IDLE_VIEW},
        '{OP_TICK,     16'h5555, 1'b1, IDLE_VIEW},
        '{OP_TICK,     16'h0000, 1'b1, FIRST_SLOT_VIEW},
        '{OP_ECHO_TWO, 16'h0064, 1'b0, IDLE_VIEW},
        '{OP_ECHO_ONE, 16'hFF00, 1'b0, IDLE_VIEW},
        '{OP_ECHO_ONE, 16'h0810, 1'b0, IDLE_VIEW},
        '{OP_ECHO_ONE, 16'h1234, 1'b0, IDLE_VIEW},
        '{OP_TICK,     16'h0000, 1'b0, IDLE_VIEW},
        '{OP_TICK,     16'h0001, 1'b0, IDLE_VIEW},
        '{OP_TICK,     16'h0002, 1'b0, IDLE_VIEW},
        '{OP_TICK,     16'h0003, 1'b0, IDLE_VIEW},
        '{OP_TICK,     16'h0004, 1'b0, IDLE_VIEW},
        '{OP_ECHO_TWO, 16'h0000, 1'b0, IDLE_VIEW},
        '{OP_ECHO_TWO, 16'hFFFF, 1'b0, IDLE_VIEW},
        '{OP_ECHO_TWO, 16'h0100, 1'b0, IDLE_VIEW},
        '{OP_TICK,     16'h8000, 1'b0, IDLE_VIEW},
        '{OP_TICK,     16'h7FFF, 1'b0, IDLE_VIEW},
        '{OP_TICK,     16'h0000, 1'b0, IDLE_VIEW},
        '{OP_TICK,     16'h0000, 1'b0, IDLE_VIEW},
        '{OP_TICK,     16'h0000, 1'b0, IDLE_VIEW}
    };

    // Settings per phase in order, extremes included; the last phase draws random settings instead.
    cfg_t phase_settings [N_PHASES] = '{
        '{9'd60,  9'd380, 4'd1,  4'd4},
        '{9'd0,   9'd0,   4'd1,  4'd1},
        '{9'd511, 9'd511, 4'd15, 4'd15},
        '{9'd100, 9'd200, 4'd0,  4'd0},
        '{9'd200, 9'd380, 4'd2,  4'd15},
        '{9'd40,  9'd380, 4'd5,  4'd4}
    };

    dual_ultrasonic_ranging_alarm_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advances the expected ranging state by one input beat and returns the
    // outputs that the block should show after it.
    function automatic result_t ranging_update(input logic [1:0] op,
                                               input logic [15:0] stamp);
        result_t     res;
        int unsigned limit;
        int unsigned count;
        int unsigned top;
        int unsigned period;
        int unsigned cm;
        logic [15:0] echo_width;
        logic [1:0]  sensor;
        logic [1:0]  fired;

        fired = SENSOR_NONE;
        if (op == OP_TICK)
        begin
            limit = (settings.ticks_per_slot == 4'd0) ? 1 : settings.ticks_per_slot;
            count = slot_count + 1;
            if (count >= limit)
            begin
                // A slot begins: trigger the other sensor and arm it.
                slot_count   = 4'd0;
                turn_sel     = (turn_sel == SENSOR_ONE) ? SENSOR_TWO : SENSOR_ONE;
                fired        = turn_sel;
                armed_unit   = turn_sel;
                rise_pending = 1'b0;

                // Only nonzero readings can become the nearest distance.
                if (range_one_cm <= range_two_cm && range_one_cm != 9'd0)
                    nearest_cm = range_one_cm;
                else if (range_two_cm < range_one_cm && range_two_cm != 9'd0)
                    nearest_cm = range_two_cm;
                warn_on = (nearest_cm <= settings.warn_distance);

                top    = (settings.longest_blink == 4'd0) ? 1 : settings.longest_blink;
                period = nearest_cm / PERIOD_STEP + 1;
                if (period > top)
                    period = top;

                if (warn_on)
                begin
                    count = blink_count + 1;
                    if (count >= period)
                    begin
                        count      = 0;
                        buzz_level = ~buzz_level;
                        led_dark   = ~led_dark;
                    end
                    blink_count = 4'(count);
                end
                else
                begin
                    buzz_level = 1'b0;
                    led_dark   = 1'b1;
                end
            end
            else
            begin
                slot_count = 4'(count);
            end
        end
        else if (op == OP_ECHO_ONE || op == OP_ECHO_TWO)
        begin
            sensor = (op == OP_ECHO_ONE) ? SENSOR_ONE : SENSOR_TWO;
            if (armed_unit == sensor)
            begin
                if (!rise_pending)
                begin
                    echo_start   = stamp;
                    rise_pending = 1'b1;
                end
                else
                begin
                    // The width wraps with the 16-bit timer.
                    echo_width = stamp - echo_start;
                    cm = echo_width / 2 / SOUND_DIVISOR;
                    if (cm <= settings.max_distance)
                    begin
                        readings_kept++;
                        if (sensor == SENSOR_ONE)
                            range_one_cm = 9'(cm);
                        else
                            range_two_cm = 9'(cm);
                    end
                    else
                    begin
                        readings_dropped++;
                    end
                    rise_pending = 1'b0;
                    armed_unit   = SENSOR_NONE;
                end
            end
        end

        res.trigger_sensor = fired;
        res.buzzer_on      = buzz_level;
        res.led_off        = led_dark;
        res.range_one      = range_one_cm;
        res.range_two      = range_two_cm;
        res.nearest_range  = nearest_cm;
        res.warning        = warn_on;
        return res;
    endfunction

    // Offers one input beat, after a random gap when send_gaps is set, and records
    // its expected result once it is accepted. A typed result replaces the predicted one.
    task automatic send_beat(input logic [1:0] op, input logic [15:0] stamp,
                             input bit typed, input result_t want);
        int         gap;
        logic [1:0] sensor;

        gap = send_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= stamp;
        do @(posedge clk); while (!s_tready);

        sensor = (op == OP_ECHO_ONE) ? SENSOR_ONE : SENSOR_TWO;
        if (op == OP_TICK || (op != OP_SPARE && armed_unit == sensor))
            useful_items++;
        last_result = ranging_update(op, stamp);
        if (last_result.trigger_sensor != SENSOR_NONE)
            slots_fired++;
        pending_results.push_back(typed ? want : last_result);
    endtask

    task automatic send_stray();
        send_beat(2'($urandom_range(0, 3)), 16'($urandom), 1'b0, IDLE_VIEW);
    endtask

    // One slot of normal use: ticks until a trigger, then the echo of the armed
    // sensor, sometimes cut short or with a stray beat in between.
    task automatic ranging_round();
        int unsigned width;
        logic [15:0] rise;
        logic [1:0]  echo_op;

        do
        begin
            if ($urandom_range(0, 9) == 0)
                send_stray();
            send_beat(OP_TICK, 16'($urandom), 1'b0, IDLE_VIEW);
        end
        while (last_result.trigger_sensor == SENSOR_NONE);

        echo_op = (armed_unit == SENSOR_ONE) ? OP_ECHO_ONE : OP_ECHO_TWO;
        case ($urandom_range(0, 7))
            0:       width = $urandom_range(0, COUNTS_PER_CM - 1);
            1:       width = $urandom_range(0, 16'hFFFF);
            default: width = $urandom_range(1, 80) * COUNTS_PER_CM
                             + $urandom_range(0, COUNTS_PER_CM - 1);
        endcase
        rise = 16'($urandom);

        if ($urandom_range(0, 11) != 0)
        begin
            send_beat(echo_op, rise, 1'b0, IDLE_VIEW);
            if ($urandom_range(0, 7) == 0)
                send_stray();
            if ($urandom_range(0, 9) != 0)
                send_beat(echo_op, 16'(rise + width), 1'b0, IDLE_VIEW);
        end
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [8:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            REG_WARN_DISTANCE:  settings.warn_distance  = value;
            REG_MAX_DISTANCE:   settings.max_distance   = value;
            REG_TICKS_PER_SLOT: settings.ticks_per_slot = value[3:0];
            REG_LONGEST_BLINK:  settings.longest_blink  = value[3:0];
            default: ;
        endcase
    endtask

    // Stops offering beats and waits until every expected result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_beat(input result_t got, input result_t want);
        results_checked++;
        if (want.warning)
            warn_beats++;
        if (got.trigger_sensor !== want.trigger_sensor || got.buzzer_on !== want.buzzer_on
            || got.led_off !== want.led_off || got.range_one !== want.range_one
            || got.range_two !== want.range_two || got.nearest_range !== want.nearest_range
            || got.warning !== want.warning)
        begin
            mismatch_count++;
            reports++;
            if (reports <= MAX_REPORTS)
                $display("Result beat %0d differs (expected/actual): trigger %0d/%0d",
                         results_checked, want.trigger_sensor, got.trigger_sensor,
                         " buzzer %0d/%0d led_off %0d/%0d range_one %0d/%0d",
                         want.buzzer_on, got.buzzer_on, want.led_off, got.led_off,
                         want.range_one, got.range_one,
                         " range_two %0d/%0d nearest %0d/%0d warning %0d/%0d",
                         want.range_two, got.range_two, want.nearest_range,
                         got.nearest_range, want.warning, got.warning);
        end
    endtask

    // Result beats are compared with the oldest outstanding expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                unexpected_count++;
                reports++;
                if (reports <= MAX_REPORTS)
                    $display("Result beat with nothing expected: %h", m_tdata);
            end
            else
            begin
                check_beat(result_t'(m_tdata), pending_results.pop_front());
            end
        end
    end

    // Result sink: a random stall before each beat when recv_gaps is set, or a long one on request.
    initial
    begin : result_sink
        int stall;

        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = recv_gaps ? $urandom_range(0, 14) : 0;
            if (hold_req > 0)
            begin
                stall    = hold_req;
                hold_req = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin : stimulus
        cfg_t next;
        int   target;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings.
        foreach (probes[i])
            send_beat(probes[i].op, probes[i].stamp, probes[i].typed, probes[i].want);

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_results();
            next = phase_settings[p];
            if (p == RANDOM_PHASE)
                next = '{9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                         4'($urandom_range(1, 15)), 4'($urandom_range(1, 15))};
            write_reg(REG_WARN_DISTANCE, next.warn_distance);
            write_reg(REG_MAX_DISTANCE, next.max_distance);
            write_reg(REG_TICKS_PER_SLOT, 9'(next.ticks_per_slot));
            write_reg(REG_LONGEST_BLINK, 9'(next.longest_blink));
            cfg_valid <= 1'b0;

            target = useful_items + ITEMS_PER_PHASE;

            // Back pressure: the sink holds off while beats keep coming.
            if (p == 0 || p == 3)
            begin
                hold_req  = STALL_LONG;
                send_gaps = 1'b0;
                repeat (4) ranging_round();
            end

            while (useful_items < target)
            begin
                send_gaps = ($urandom_range(0, 3) != 0);
                recv_gaps = ($urandom_range(0, 3) != 0);
                repeat (3) ranging_round();
            end
        end

        drain_results();
        $display("Sent %0d effective beats under %0d settings: %0d slots fired,",
                 useful_items, N_PHASES + 1, slots_fired);
        $display("%0d echoes kept, %0d beyond range; %0d results checked, %0d warning.",
                 readings_kept, readings_dropped, results_checked, warn_beats);
        if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0)
            $display("tb_dual_ultrasonic_ranging_alarm_top: clean");
        else
            $display("tb_dual_ultrasonic_ranging_alarm_top: errors");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("tb_dual_ultrasonic_ranging_alarm_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
